// ----- hdl/hpsc_pkg.sv -----
// Shared constants, register indexes and stage types of the heading PI sweep controller.
package hpsc_pkg;

    localparam int ANGLE_COUNTS = 4096;
    localparam int ANGLE_BITS   = $clog2(ANGLE_COUNTS);

    localparam int RAW_W   = 12;
    localparam int HEAD_W  = 15;
    localparam int DIFF_W  = 17;
    localparam int ERR_W   = 15;
    localparam int TGT_W   = 10;
    localparam int TOP_W   = 9;
    localparam int DZ_W    = 10;
    localparam int GAIN_W  = 16;
    localparam int CRUISE_W = 20;
    localparam int SPD_W   = 32;
    localparam int PROD_I_W = GAIN_W + 1 + SPD_W;
    localparam int PSUM_W  = PROD_I_W + 1;
    localparam int HALF_W  = SPD_W - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CRUISE_W;

    localparam int FULL_CIRCLE = 23040;
    localparam int HALF_CIRCLE = 11520;
    localparam int TOP_LIMIT   = 359;

    localparam logic [RAW_W-1:0]         RAW_MASK      = RAW_W'(ANGLE_COUNTS - 1);
    localparam logic signed [DIFF_W-1:0] FULL_CIRCLE_S = DIFF_W'(FULL_CIRCLE);
    localparam logic signed [DIFF_W-1:0] HALF_CIRCLE_S = DIFF_W'(HALF_CIRCLE);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_TOP    = 3'd4;

    // Tracking front end result: wrapped error, integrator before dead zone clear
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [SPD_W-1:0] sum;
        logic                    dead;
        logic signed [TGT_W-1:0] target;
    } trk_t;

    // Side information carried down the PI stages
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    dead;
        logic signed [TGT_W-1:0] target;
    } side_t;

endpackage

// ----- hdl/hpsc_track.sv -----
// Target sweep, wrapped heading error and saturating integrator (two pipeline stages).
module hpsc_track (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [hpsc_pkg::RAW_W-1:0]      raw_angle,
    input  logic [hpsc_pkg::TOP_W-1:0]      sweep_top,
    input  logic [hpsc_pkg::DZ_W-1:0]       dead_zone,
    output logic                            trk_valid,
    input  logic                            trk_ready,
    output hpsc_pkg::trk_t                  trk
);
    import hpsc_pkg::*;

    logic signed [TGT_W-1:0]  target_reg, target_next;
    logic                     up_reg, up_next;
    logic signed [SPD_W-1:0]  sum_reg, sum_next;

    logic                     v1_reg, v2_reg;
    logic signed [ERR_W-1:0]  err1_reg;
    logic signed [TGT_W-1:0]  tgt1_reg;
    trk_t                     trk_reg;

    logic                     rdy1, rdy2, accept, load2;
    logic signed [TGT_W-1:0]  top_eff, tgt_step;
    logic                     up_step;
    logic [RAW_W+HEAD_W-1:0]  head_prod;
    logic [HEAD_W-1:0]        heading;
    logic signed [DIFF_W-1:0] tgt_scaled, diff, wrapped;
    logic signed [ERR_W-1:0]  err_wrap;
    logic signed [SPD_W:0]    sum_wide;
    logic signed [SPD_W-1:0]  sum_sat;
    logic [ERR_W-1:0]         err_mag;
    logic                     dead;

    assign rdy2    = !v2_reg || trk_ready;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign accept  = s_valid && rdy1;
    assign load2   = v1_reg && rdy2;

    // Triangle sweep step, taken once per accepted sample
    always_comb begin
        top_eff = (sweep_top > TOP_W'(TOP_LIMIT)) ? TGT_W'(TOP_LIMIT)
                                                  : {1'b0, sweep_top};
        if (up_reg) begin
            tgt_step = target_reg + 10'sd1;
            up_step  = (tgt_step <= top_eff);
        end else begin
            tgt_step = target_reg - 10'sd1;
            up_step  = (tgt_step <= 10'sd0);
        end
        target_next = accept ? tgt_step : target_reg;
        up_next     = accept ? up_step : up_reg;
    end

    // Heading in 1/64 degree and error wrapped to +/- 180 degrees
    always_comb begin
        head_prod  = (RAW_W+HEAD_W)'(raw_angle & RAW_MASK) * (RAW_W+HEAD_W)'(FULL_CIRCLE);
        heading    = HEAD_W'(head_prod >> ANGLE_BITS);
        tgt_scaled = {tgt_step[TGT_W-1], tgt_step, 6'b0};
        diff       = $signed({2'b00, heading}) - tgt_scaled;
        if (diff > HALF_CIRCLE_S) begin
            wrapped = diff - FULL_CIRCLE_S;
        end else if (diff < -HALF_CIRCLE_S) begin
            wrapped = diff + FULL_CIRCLE_S;
        end else begin
            wrapped = diff;
        end
        err_wrap = ERR_W'(wrapped);
    end

    // Saturating integrator; clear it inside the dead zone
    always_comb begin
        sum_wide = (SPD_W+1)'(sum_reg) + (SPD_W+1)'(err1_reg);
        if (sum_wide[SPD_W] != sum_wide[SPD_W-1]) begin
            sum_sat = sum_wide[SPD_W] ? {1'b1, {(SPD_W-1){1'b0}}} : {1'b0, {(SPD_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SPD_W-1:0];
        end
        err_mag  = err1_reg[ERR_W-1] ? ERR_W'(-err1_reg) : ERR_W'(err1_reg);
        dead     = (err_mag < ERR_W'(dead_zone));
        sum_next = load2 ? (dead ? '0 : sum_sat) : sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            up_reg     <= 1'b1;
            sum_reg    <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end else begin
            target_reg <= target_next;
            up_reg     <= up_next;
            sum_reg    <= sum_next;
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            err1_reg <= err_wrap;
            tgt1_reg <= tgt_step;
        end
        if (load2) begin
            trk_reg.err    <= err1_reg;
            trk_reg.sum    <= sum_sat;
            trk_reg.dead   <= dead;
            trk_reg.target <= tgt1_reg;
        end
    end

    assign trk_valid = v2_reg;
    assign trk       = trk_reg;

endmodule

// ----- hdl/heading_pi_sweep_controller_top.sv -----
// Top level of the heading PI sweep controller: config registers, PI stages, output register.
//
// Usage:
//   Input channel s_valid/s_ready/s_raw_angle carries one encoder sample per control
//   tick. Each transaction steps the triangle sweep target, forms the wrapped heading
//   error, updates the saturating integrator and yields exactly one result on
//   m_valid/m_ready: left/right drive speeds, the error, the target and the PI turn term.
//   Config port cfg_valid/cfg_ready/cfg_index/cfg_data writes one register per
//   transaction (0 prop_gain, 1 integ_gain, 2 cruise_speed, 3 dead_zone, 4 sweep_top);
//   cfg_ready is always high, unknown indexes are dropped. Write only while idle.
//   Six register stages, two in hpsc_track and four here. The pipeline takes one
//   sample per cycle while the receiver does not stall, as the integrator loop in
//   stage two closes through one register and the multiply and scale path is fully pipelined.
//   Reset (aresetn low, synchronous) empties the pipeline, sets the target to zero
//   sweeping up, clears the integrator and loads the register defaults.
//   When the receiver stalls, the result holds in the output register and earlier
//   stages keep filling; s_ready drops only once every stage holds a sample.
module heading_pi_sweep_controller_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [hpsc_pkg::RAW_W-1:0]            s_raw_angle,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [hpsc_pkg::SPD_W-1:0]     m_left_speed,
    output logic signed [hpsc_pkg::SPD_W-1:0]     m_right_speed,
    output logic signed [hpsc_pkg::ERR_W-1:0]     m_heading_error,
    output logic signed [hpsc_pkg::TGT_W-1:0]     m_target_heading,
    output logic signed [hpsc_pkg::SPD_W-1:0]     m_turn_speed,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hpsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hpsc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import hpsc_pkg::*;

    logic [GAIN_W-1:0]   prop_gain_reg, prop_gain_next;
    logic [GAIN_W-1:0]   integ_gain_reg, integ_gain_next;
    logic [CRUISE_W-1:0] cruise_reg, cruise_next;
    logic [DZ_W-1:0]     dead_zone_reg, dead_zone_next;
    logic [TOP_W-1:0]    sweep_top_reg, sweep_top_next;

    logic                trk_valid, trk_ready;
    trk_t                trk;

    logic                v3_reg, v4_reg, v5_reg, v6_reg;
    logic                rdy3, rdy4, rdy5, rdy6;
    side_t               side3_reg, side4_reg, side5_reg;

    logic signed [SPD_W-1:0]    prod_p, prod_p3_reg;
    logic signed [PROD_I_W-1:0] prod_i, prod_i3_reg;
    logic signed [PSUM_W-1:0]   psum, psum4_reg;
    logic                       neg;
    logic signed [PSUM_W-1:0]   q_shift, h_shift;
    logic signed [SPD_W-1:0]    turn, turn5_reg;
    logic signed [HALF_W-1:0]   half_turn, half5_reg;
    logic signed [SPD_W-1:0]    half_cruise, base;

    logic signed [SPD_W-1:0]    left_reg, right_reg, turn6_reg;
    logic signed [ERR_W-1:0]    err6_reg;
    logic signed [TGT_W-1:0]    tgt6_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        prop_gain_next  = prop_gain_reg;
        integ_gain_next = integ_gain_reg;
        cruise_next     = cruise_reg;
        dead_zone_next  = dead_zone_reg;
        sweep_top_next  = sweep_top_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:    prop_gain_next  = cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:   integ_gain_next = cfg_data[GAIN_W-1:0];
                CFG_CRUISE_SPEED: cruise_next     = cfg_data[CRUISE_W-1:0];
                CFG_DEAD_ZONE:    dead_zone_next  = cfg_data[DZ_W-1:0];
                CFG_SWEEP_TOP:    sweep_top_next  = cfg_data[TOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= GAIN_W'(1000);
            integ_gain_reg <= '0;
            cruise_reg     <= CRUISE_W'(200000);
            dead_zone_reg  <= DZ_W'(1);
            sweep_top_reg  <= TOP_W'(270);
        end else begin
            prop_gain_reg  <= prop_gain_next;
            integ_gain_reg <= integ_gain_next;
            cruise_reg     <= cruise_next;
            dead_zone_reg  <= dead_zone_next;
            sweep_top_reg  <= sweep_top_next;
        end
    end

    hpsc_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .raw_angle (s_raw_angle),
        .sweep_top (sweep_top_reg),
        .dead_zone (dead_zone_reg),
        .trk_valid (trk_valid),
        .trk_ready (trk_ready),
        .trk       (trk)
    );

    // Stage handshake: a stage loads when it is empty or its successor loads
    assign rdy6      = !v6_reg || m_ready;
    assign rdy5      = !v5_reg || rdy6;
    assign rdy4      = !v4_reg || rdy5;
    assign rdy3      = !v3_reg || rdy4;
    assign trk_ready = rdy3;

    // Stage 3: gain products
    assign prod_p = $signed({1'b0, prop_gain_reg}) * $signed(trk.err);
    assign prod_i = $signed({1'b0, integ_gain_reg}) * $signed(trk.sum);

    // Stage 4: PI sum in 1/64 units
    assign psum = PSUM_W'(prod_p3_reg) + PSUM_W'(prod_i3_reg);

    // Stage 5: divide by 64 and by 128 toward zero, then saturate
    always_comb begin
        neg     = psum4_reg[PSUM_W-1];
        q_shift = (psum4_reg + (neg ? PSUM_W'(63) : PSUM_W'(0))) >>> 6;
        h_shift = (psum4_reg + (neg ? PSUM_W'(127) : PSUM_W'(0))) >>> 7;
        if ((&q_shift[PSUM_W-1:SPD_W-1]) || !(|q_shift[PSUM_W-1:SPD_W-1])) begin
            turn = q_shift[SPD_W-1:0];
        end else begin
            turn = neg ? {1'b1, {(SPD_W-1){1'b0}}} : {1'b0, {(SPD_W-1){1'b1}}};
        end
        if ((&h_shift[PSUM_W-1:HALF_W-1]) || !(|h_shift[PSUM_W-1:HALF_W-1])) begin
            half_turn = h_shift[HALF_W-1:0];
        end else begin
            half_turn = neg ? {1'b1, {(HALF_W-1){1'b0}}} : {1'b0, {(HALF_W-1){1'b1}}};
        end
    end

    // Stage 6: drive speeds; the sum stays inside 32 bits, so no clamp is needed
    always_comb begin
        half_cruise = {{(SPD_W-CRUISE_W+1){1'b0}}, cruise_reg[CRUISE_W-1:1]};
        base        = side5_reg.dead ? '0 : SPD_W'(half5_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy3) begin
                v3_reg <= trk_valid;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && trk_valid) begin
            prod_p3_reg      <= prod_p;
            prod_i3_reg      <= prod_i;
            side3_reg.err    <= trk.err;
            side3_reg.dead   <= trk.dead;
            side3_reg.target <= trk.target;
        end
        if (rdy4 && v3_reg) begin
            psum4_reg <= psum;
            side4_reg <= side3_reg;
        end
        if (rdy5 && v4_reg) begin
            turn5_reg <= turn;
            half5_reg <= half_turn;
            side5_reg <= side4_reg;
        end
        if (rdy6 && v5_reg) begin
            left_reg  <= base + half_cruise;
            right_reg <= base - half_cruise;
            turn6_reg <= turn5_reg;
            err6_reg  <= side5_reg.err;
            tgt6_reg  <= side5_reg.target;
        end
    end

    assign m_valid          = v6_reg;
    assign m_left_speed     = left_reg;
    assign m_right_speed    = right_reg;
    assign m_heading_error  = err6_reg;
    assign m_target_heading = tgt6_reg;
    assign m_turn_speed     = turn6_reg;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the heading PI sweep controller: directed table plus random phases.
module tb;
    import hpsc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 167;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PCT    = 38;

    typedef struct packed {
        logic signed [SPD_W-1:0] left;
        logic signed [SPD_W-1:0] right;
        logic signed [ERR_W-1:0] err;
        logic signed [TGT_W-1:0] target;
        logic signed [SPD_W-1:0] turn;
    } drive_cmd_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [RAW_W-1:0]      raw;
        bit                    typed;
        drive_cmd_t            want;
    } step_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [RAW_W-1:0]        s_raw_angle;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [SPD_W-1:0] m_left_speed;
    logic signed [SPD_W-1:0] m_right_speed;
    logic signed [ERR_W-1:0] m_heading_error;
    logic signed [TGT_W-1:0] m_target_heading;
    logic signed [SPD_W-1:0] m_turn_speed;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Predictor copy of the registers and the loop state
    int     gain_p, gain_i, cruise, deadband, top_deg;
    int     tgt_deg;
    bit     rising;
    longint err_acc;

    drive_cmd_t pending_cmds[$];
    step_row_t  rows[$];
    int         fail_count = 0;
    int         send_idle;
    int         rx_idle;
    bit         hold_req;

    heading_pi_sweep_controller_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_angle      (s_raw_angle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_speed     (m_left_speed),
        .m_right_speed    (m_right_speed),
        .m_heading_error  (m_heading_error),
        .m_target_heading (m_target_heading),
        .m_turn_speed     (m_turn_speed),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void reset_model();
        gain_p   = 1000;
        gain_i   = 0;
        cruise   = 200000;
        deadband = 1;
        top_deg  = 270;
        tgt_deg  = 0;
        rising   = 1'b1;
        err_acc  = 0;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_PROP_GAIN:    gain_p   = int'(d[GAIN_W-1:0]);
            CFG_INTEG_GAIN:   gain_i   = int'(d[GAIN_W-1:0]);
            CFG_CRUISE_SPEED: cruise   = int'(d[CRUISE_W-1:0]);
            CFG_DEAD_ZONE:    deadband = int'(d[DZ_W-1:0]);
            CFG_SWEEP_TOP:    top_deg  = int'(d[TOP_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advance the sweep and the integrator by one sample, return the drive command
    function automatic drive_cmd_t steer_step(input logic [RAW_W-1:0] raw);
        int         top;
        longint     heading, err, mag, turn, half_cruise, lft, rgt;
        drive_cmd_t c;
        top = (top_deg > TOP_LIMIT) ? TOP_LIMIT : top_deg;
        if (rising) begin
            tgt_deg = tgt_deg + 1;
            rising  = (tgt_deg <= top);
        end else begin
            tgt_deg = tgt_deg - 1;
            rising  = (tgt_deg <= 0);
        end
        heading = (longint'(raw % ANGLE_COUNTS) * FULL_CIRCLE) / ANGLE_COUNTS;
        err = heading - longint'(tgt_deg) * 64;
        if (err > HALF_CIRCLE) err = err - FULL_CIRCLE;
        if (err < -HALF_CIRCLE) err = err + FULL_CIRCLE;
        err_acc = clamp_s32(err_acc + err);
        turn = clamp_s32((longint'(gain_p) * err + longint'(gain_i) * err_acc) / 64);
        half_cruise = cruise / 2;
        mag = (err < 0) ? -err : err;
        if (mag < deadband) begin
            err_acc = 0;
            lft = half_cruise;
            rgt = -half_cruise;
        end else begin
            lft = clamp_s32(turn / 2 + half_cruise);
            rgt = clamp_s32(turn / 2 - half_cruise);
        end
        c.left   = SPD_W'(lft);
        c.right  = SPD_W'(rgt);
        c.err    = ERR_W'(err);
        c.target = TGT_W'(tgt_deg);
        c.turn   = SPD_W'(turn);
        return c;
    endfunction

    function automatic void note_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic step_row_t item_row(input logic [RAW_W-1:0] raw);
        step_row_t r;
        r.is_write = 1'b0;
        r.idx      = '0;
        r.data     = '0;
        r.raw      = raw;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic step_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] d);
        step_row_t r;
        r          = item_row('0);
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = d;
        return r;
    endfunction

    function automatic step_row_t typed_row(input logic [RAW_W-1:0] raw, input int l,
                                            input int rt, input int e, input int t,
                                            input int tr);
        step_row_t r;
        r             = item_row(raw);
        r.typed       = 1'b1;
        r.want.left   = SPD_W'(l);
        r.want.right  = SPD_W'(rt);
        r.want.err    = ERR_W'(e);
        r.want.target = TGT_W'(t);
        r.want.turn   = SPD_W'(tr);
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_value(input int w);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_DATA_W'((1 << w) - 1);
            default: return CFG_DATA_W'($urandom_range(0, (1 << w) - 1));
        endcase
    endfunction

    // Mostly uniform, some extremes, some close to the target to hit the dead zone
    function automatic logic [RAW_W-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? RAW_MASK : '0;
            1, 2, 3: return RAW_W'(tgt_deg * ANGLE_COUNTS / 360
                                   + int'($urandom_range(0, 40)) - 20);
            default: return RAW_W'($urandom_range(0, ANGLE_COUNTS - 1));
        endcase
    endfunction

    task automatic send_angle(input logic [RAW_W-1:0] raw, input bit typed,
                              input drive_cmd_t want);
        drive_cmd_t got;
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_raw_angle <= raw;
        do @(posedge aclk); while (!s_ready);
        got = steer_step(raw);
        pending_cmds.push_back(typed ? want : got);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        store_reg(idx, d);
    endtask

    // Drop the input and wait until every pending command has come out
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
    endtask

    task automatic take_result();
        drive_cmd_t want;
        if (pending_cmds.size() == 0) begin
            note_fail($sformatf("unexpected result transaction: L=%0d R=%0d",
                                m_left_speed, m_right_speed));
            return;
        end
        want = pending_cmds.pop_front();
        if (m_left_speed !== want.left || m_right_speed !== want.right ||
            m_heading_error !== want.err || m_target_heading !== want.target ||
            m_turn_speed !== want.turn)
            note_fail($sformatf({"mismatch: expected L=%0d R=%0d err=%0d tgt=%0d turn=%0d,",
                                 " got L=%0d R=%0d err=%0d tgt=%0d turn=%0d"},
                                want.left, want.right, want.err, want.target, want.turn,
                                m_left_speed, m_right_speed, m_heading_error,
                                m_target_heading, m_turn_speed));
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) take_result();
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle);
            end
        end
    end

    initial begin : stimulus
        bit cfg_open;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_raw_angle = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        send_idle   = IDLE_PCT;
        rx_idle     = IDLE_PCT;
        hold_req    = 1'b0;
        cfg_open    = 1'b0;
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // First two samples after reset with default gains
        rows.push_back(typed_row(12'd0, 99500, -100500, -64, 1, -1000));
        rows.push_back(typed_row(12'd4095, 98954, -101046, -134, 2, -2093));
        rows.push_back(item_row(12'd2048));
        rows.push_back(item_row(12'd2100));
        rows.push_back(write_row(CFG_DEAD_ZONE, 20'd1023));
        rows.push_back(item_row(12'd0));
        rows.push_back(item_row(12'd100));
        rows.push_back(write_row(CFG_DEAD_ZONE, 20'd0));
        rows.push_back(write_row(CFG_PROP_GAIN, 20'd65535));
        rows.push_back(write_row(CFG_INTEG_GAIN, 20'd65535));
        rows.push_back(write_row(CFG_CRUISE_SPEED, 20'hFFFFF));
        rows.push_back(item_row(12'd4095));
        rows.push_back(item_row(12'd2048));
        rows.push_back(item_row(12'd0));
        rows.push_back(write_row(CFG_SWEEP_TOP, 20'd511));
        rows.push_back(item_row(12'd1));
        // Lower the top below the current target: the sweep must turn around
        rows.push_back(write_row(CFG_SWEEP_TOP, 20'd0));
        rows.push_back(item_row(12'd2));
        rows.push_back(item_row(12'd3));
        rows.push_back(item_row(12'd4));
        rows.push_back(write_row(CFG_SPARE_LO, 20'h5A5A5));
        rows.push_back(write_row(CFG_SPARE_HI, 20'hFFFFF));
        rows.push_back(write_row(CFG_PROP_GAIN, 20'd0));
        rows.push_back(write_row(CFG_INTEG_GAIN, 20'd0));
        rows.push_back(write_row(CFG_CRUISE_SPEED, 20'd0));
        rows.push_back(item_row(12'd1234));
        rows.push_back(item_row(12'd3000));

        foreach (rows[k]) begin
            if (rows[k].is_write) begin
                if (!cfg_open) settle();
                write_reg(rows[k].idx, rows[k].data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_angle(rows[k].raw, rows[k].typed, rows[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(CFG_PROP_GAIN, pick_value(GAIN_W));
            write_reg(CFG_INTEG_GAIN, pick_value(GAIN_W));
            write_reg(CFG_CRUISE_SPEED, pick_value(CRUISE_W));
            write_reg(CFG_DEAD_ZONE, ($urandom_range(0, 2) == 0) ? pick_value(DZ_W)
                                     : CFG_DATA_W'($urandom_range(0, 120)));
            write_reg(CFG_SWEEP_TOP, pick_value(TOP_W));
            if ($urandom_range(0, 1))
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          pick_value(CFG_DATA_W));
            cfg_valid <= 1'b0;
            // Phase 0 runs without gaps, phase 1 keeps offering while the sink holds off
            send_idle = (p < 2) ? 0 : IDLE_PCT;
            rx_idle   = (p == 0) ? 0 : IDLE_PCT;
            if (p == 1) hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_angle(pick_angle(), 1'b0, '0);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_cmds.size() != 0)
            note_fail($sformatf("%0d expected results never arrived", pending_cmds.size()));
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
